// ----- src/ghalloc_pkg.sv -----
// Shared types and constants for the generational handle allocator.
package ghalloc_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int GEN_W      = 32;
    localparam int IDX_W      = 32;
    localparam int HANDLE_W   = GEN_W + IDX_W;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_SLOT_W = 6;
    localparam int S_TDATA_W  = ((OP_W + HANDLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((STATUS_W + HANDLE_W + OUT_SLOT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_POP  = 2'd1,
        S_GEN  = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic gen_rd;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ----- src/ghalloc_ctrl.sv -----
// Controller state machine: sequences load, table read and commit of one beat.
module ghalloc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ghalloc_pkg::dp_stat_t stat,
    output ghalloc_pkg::dp_cmd_t  cmd
);

    ghalloc_pkg::state_t state_reg;
    ghalloc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ghalloc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ghalloc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ghalloc_pkg::S_POP;
                end
            end
            ghalloc_pkg::S_POP: begin
                state_next = ghalloc_pkg::S_GEN;
            end
            ghalloc_pkg::S_GEN: begin
                if (stat.out_free) begin
                    state_next = ghalloc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ghalloc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.gen_rd = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ghalloc_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ghalloc_pkg::S_POP: begin
                cmd.gen_rd = 1'b1;
            end
            ghalloc_pkg::S_GEN: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/ghalloc_dp.sv -----
// Datapath: slot tables, free stack, handle check and output register.
module ghalloc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ghalloc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ghalloc_pkg::M_TDATA_W-1:0] m_tdata,
    input  ghalloc_pkg::dp_cmd_t              cmd,
    output ghalloc_pkg::dp_stat_t             stat
);

    localparam int SW = ghalloc_pkg::SLOT_W;
    localparam int CW = ghalloc_pkg::CNT_W;
    localparam int GW = ghalloc_pkg::GEN_W;
    localparam int IW = ghalloc_pkg::IDX_W;
    localparam int HW = ghalloc_pkg::HANDLE_W;
    localparam int OW = ghalloc_pkg::OP_W;

    logic [GW-1:0] gen_mem   [ghalloc_pkg::NUM_SLOTS];
    logic [SW-1:0] stack_mem [ghalloc_pkg::NUM_SLOTS];

    ghalloc_pkg::op_t               op_reg;
    logic [HW-1:0]                  handle_reg;
    logic [SW-1:0]                  slot_reg;
    logic [GW-1:0]                  gen_q;
    logic [SW-1:0]                  stack_q;
    logic [ghalloc_pkg::NUM_SLOTS-1:0] in_use_reg;
    logic [CW-1:0]                  free_count_reg;
    logic [CW-1:0]                  created_reg;
    logic                           m_tvalid_reg;
    logic [ghalloc_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [SW-1:0]        stack_raddr;
    logic [SW-1:0]        slot_sel;
    logic                 handle_ok;
    ghalloc_pkg::status_t res_status;
    logic [HW-1:0]        res_handle;
    logic [SW-1:0]        res_slot;
    logic                 gen_we;
    logic [SW-1:0]        gen_wslot;
    logic [GW-1:0]        gen_wdata;
    logic                 use_set;
    logic                 use_clr;
    logic                 push;
    logic                 pop;
    logic                 create;
    logic                 clear;

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    assign stack_raddr = free_count_reg[SW-1:0] - SW'(1);
    assign slot_sel    = (op_reg == ghalloc_pkg::OP_ACQUIRE) ? stack_q
                                                             : handle_reg[SW-1:0];

    // operand capture and table reads
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= ghalloc_pkg::op_t'(s_tdata[OW-1:0]);
            handle_reg <= s_tdata[OW+HW-1:OW];
        end
        stack_q <= stack_mem[stack_raddr];
        if (push) begin
            stack_mem[free_count_reg[SW-1:0]] <= slot_reg;
        end
        if (cmd.gen_rd) begin
            gen_q    <= gen_mem[slot_sel];
            slot_reg <= slot_sel;
        end
        if (gen_we) begin
            gen_mem[gen_wslot] <= gen_wdata;
        end
    end

    assign handle_ok = (handle_reg != '0)
                    && (handle_reg[IW-1:0] < IW'(created_reg))
                    && in_use_reg[slot_reg]
                    && (gen_q == handle_reg[HW-1:IW]);

    always_comb begin
        res_status = ghalloc_pkg::ST_OK;
        res_handle = '0;
        res_slot   = '0;
        gen_we     = 1'b0;
        gen_wslot  = slot_reg;
        gen_wdata  = gen_q + GW'(1);
        use_set    = 1'b0;
        use_clr    = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        create     = 1'b0;
        clear      = 1'b0;
        unique case (op_reg)
            ghalloc_pkg::OP_ACQUIRE: begin
                if (free_count_reg != '0) begin
                    pop        = cmd.commit;
                    use_set    = cmd.commit;
                    gen_we     = cmd.commit;
                    res_slot   = slot_reg;
                    res_handle = {gen_wdata, IW'(slot_reg)};
                end else if (created_reg < CW'(ghalloc_pkg::NUM_SLOTS)) begin
                    create     = cmd.commit;
                    use_set    = cmd.commit;
                    gen_we     = cmd.commit;
                    gen_wslot  = created_reg[SW-1:0];
                    gen_wdata  = GW'(1);
                    res_slot   = created_reg[SW-1:0];
                    res_handle = {GW'(1), IW'(created_reg[SW-1:0])};
                end else begin
                    res_status = ghalloc_pkg::ST_FULL;
                end
            end
            ghalloc_pkg::OP_RELEASE: begin
                if (handle_ok) begin
                    use_clr  = cmd.commit;
                    gen_we   = cmd.commit;
                    push     = cmd.commit
                            && (free_count_reg < CW'(ghalloc_pkg::NUM_SLOTS));
                    res_slot = slot_reg;
                end else begin
                    res_status = ghalloc_pkg::ST_NOT_FOUND;
                end
            end
            ghalloc_pkg::OP_LOOKUP: begin
                if (handle_ok) begin
                    res_slot = slot_reg;
                end else begin
                    res_status = ghalloc_pkg::ST_NOT_FOUND;
                end
            end
            ghalloc_pkg::OP_CLEAR: begin
                clear = cmd.commit;
            end
            default: begin
                res_status = ghalloc_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg     <= '0;
            free_count_reg <= '0;
            created_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (clear) begin
                in_use_reg     <= '0;
                free_count_reg <= '0;
                created_reg    <= '0;
            end else begin
                if (use_set) begin
                    in_use_reg[gen_wslot] <= 1'b1;
                end
                if (use_clr) begin
                    in_use_reg[gen_wslot] <= 1'b0;
                end
                if (pop) begin
                    free_count_reg <= free_count_reg - CW'(1);
                end else if (push) begin
                    free_count_reg <= free_count_reg + CW'(1);
                end
                if (create) begin
                    created_reg <= created_reg + CW'(1);
                end
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {ghalloc_pkg::OUT_SLOT_W'(res_slot), res_handle, res_status};
        end
    end

endmodule

// ----- src/generational_handle_allocator_unit.sv -----
// Generational handle allocator: top level with controller and datapath.
//
// Slave stream: one beat is one command (acquire, release, lookup, clear)
// with a 64-bit handle. Master stream: one beat per command with a status,
// the new handle on acquire and the slot index.
// Handles are a 32-bit generation above a 32-bit slot index; freed slots
// are reused last-in first-out, fresh slots start at generation 1.
// An accepted command beat goes through capture with free stack read,
// generation table read and commit into the output register.
// The generation read waits on the slot from the free stack; the next
// command is accepted only in the idle state after the previous commit.
// The output register lets the next command be taken while a result beat
// waits; a stalled receiver holds the second command in its commit step.
// Reset (aresetn low, synchronous) empties the table: all in-use bits,
// the free count and the created count go to zero and the output is idle.
// No clearing pass is needed after reset.
module generational_handle_allocator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ghalloc_pkg::S_TDATA_W-1:0] s_tdata,  // opcode, handle_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ghalloc_pkg::M_TDATA_W-1:0] m_tdata   // status, handle_out, slot_index
);

    ghalloc_pkg::dp_cmd_t  cmd;
    ghalloc_pkg::dp_stat_t stat;

    ghalloc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ghalloc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    localparam int HLO = ghalloc_pkg::STATUS_W;
    localparam int HHI = ghalloc_pkg::STATUS_W + ghalloc_pkg::HANDLE_W - 1;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("command accepted before previous one committed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ghalloc_pkg::STATUS_W-1:0] != ghalloc_pkg::ST_OK)
        |-> (m_tdata[HHI:HLO] == '0) && (m_tdata[ghalloc_pkg::M_TDATA_W-1:HHI+1] == '0))
        else $error("failed command returned nonzero handle or slot");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_free)
        else $error("result written over a pending beat");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

endmodule
